// ===== src/lane_marking_row_filter_core_defines.svh =====
// Assertion macros shared by the filter modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef LANE_MARKING_ROW_FILTER_CORE_DEFINES_SVH
`define LANE_MARKING_ROW_FILTER_CORE_DEFINES_SVH

`define LMRF_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define LMRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lmrf_pkg.sv =====
package lmrf_pkg;

    localparam int PIX_W       = 8;
    localparam int TAU_W       = 5;
    localparam int ROW_W       = 12;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_TAU        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GATE_LEVEL = 2'd2;

    localparam logic [TAU_W-1:0] TAU_RESET       = 5'd4;
    localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 12'd640;
    localparam logic [PIX_W-1:0] GATE_RESET      = 8'd130;
    localparam logic [PIX_W-1:0] PIX_MAX         = 8'd255;

    localparam int CMD_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic             main;
        logic [PIX_W-1:0] fval;
        logic [TAU_W-1:0] rem;
    } t_cmd;

endpackage

// ===== src/lmrf_cmd_queue.sv =====
`include "lane_marking_row_filter_core_defines.svh"

module lmrf_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lmrf_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output lmrf_pkg::t_cmd o_data,
    output logic          o_empty
);

    localparam int DEPTH = lmrf_pkg::CMD_QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    lmrf_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [NW-1:0]  r_count;
    logic           push_en;
    logic           pop_en;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_en = i_push && !o_full;
    assign pop_en  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_en) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_en) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_en && !pop_en) begin
                r_count <= r_count + 1'b1;
            end else if (pop_en && !push_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `LMRF_ASSERT(a_count_bound, 1'b1, r_count <= NW'(DEPTH), "command queue count overflow")

endmodule

// ===== src/lmrf_front.sv =====
`include "lane_marking_row_filter_core_defines.svh"

module lmrf_front #(
    parameter int TAU_MAX   = 16,
    parameter int MAX_WIDTH = 2048
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lmrf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lmrf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_push,
    input  logic [lmrf_pkg::PIX_W-1:0]       i_pixel,
    output logic                             o_full,
    output logic                             o_cmd_push,
    output lmrf_pkg::t_cmd                   o_cmd,
    input  logic                             i_cmd_full
);

    localparam int PW    = lmrf_pkg::PIX_W;
    localparam int TW    = lmrf_pkg::TAU_W;
    localparam int AW    = $clog2(2 * TAU_MAX + 1);
    localparam int DEPTH = 2 ** AW;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CX    = CW + 1;
    localparam int WW0   = $clog2(MAX_WIDTH + 1);
    localparam int XW    = (WW0 > lmrf_pkg::ROW_W) ? WW0 : lmrf_pkg::ROW_W;

    logic [TW-1:0]              r_tau;
    logic [lmrf_pkg::ROW_W-1:0] r_width;
    logic [PW-1:0]              r_gate;

    logic [PW-1:0]  r_line [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [CW-1:0]  r_col;

    logic           r_b_valid;
    logic [PW-1:0]  r_b_pix;
    logic [PW-1:0]  r_b_centre;
    logic [PW-1:0]  r_b_left;
    logic           r_b_main;
    logic           r_b_filt_ok;
    logic [TW-1:0]  r_b_flush;

    logic [TW-1:0]   tau_eff;
    logic [XW-1:0]   width_eff;
    logic            in_accept;
    logic            last;
    logic            has_main;
    logic            filt_ok;
    logic [TW-1:0]   n_flush;
    logic [CX-1:0]   col_ext;
    logic [CX-1:0]   tau_ext;
    logic [CX-1:0]   tau2_ext;
    logic            b_need;
    logic            b_stall;
    logic [PW-1:0]   hi;
    logic [PW-1:0]   diff;
    logic [PW-1:0]   fval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau   <= lmrf_pkg::TAU_RESET;
            r_width <= lmrf_pkg::ROW_WIDTH_RESET;
            r_gate  <= lmrf_pkg::GATE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lmrf_pkg::CFG_TAU:        r_tau   <= i_cfg_data[TW-1:0];
                lmrf_pkg::CFG_ROW_WIDTH:  r_width <= i_cfg_data[lmrf_pkg::ROW_W-1:0];
                lmrf_pkg::CFG_GATE_LEVEL: r_gate  <= i_cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_tau == '0) begin
            tau_eff = TW'(1);
        end else if (32'(r_tau) > TAU_MAX) begin
            tau_eff = TW'(TAU_MAX);
        end else begin
            tau_eff = r_tau;
        end
        if (r_width == '0) begin
            width_eff = XW'(1);
        end else if (XW'(r_width) > XW'(MAX_WIDTH)) begin
            width_eff = XW'(MAX_WIDTH);
        end else begin
            width_eff = XW'(r_width);
        end
    end

    assign col_ext  = CX'(r_col);
    assign tau_ext  = CX'(tau_eff);
    assign tau2_ext = CX'({tau_eff, 1'b0});
    assign last     = ((XW + 1)'(r_col) + 1'b1) >= (XW + 1)'(width_eff);
    assign has_main = col_ext >= tau_ext;
    assign filt_ok  = col_ext >= tau2_ext;

    always_comb begin
        if (!last) begin
            n_flush = '0;
        end else if ((col_ext + 1'b1) < tau_ext) begin
            n_flush = TW'(col_ext + 1'b1);
        end else begin
            n_flush = tau_eff;
        end
    end

    assign b_need    = r_b_main || (r_b_flush != '0);
    assign b_stall   = r_b_valid && b_need && i_cmd_full;
    assign o_full    = b_stall;
    assign in_accept = i_push && !b_stall;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_line[r_wr_ptr] <= i_pixel;
            r_b_centre       <= r_line[r_wr_ptr - AW'(tau_eff)];
            r_b_left         <= r_line[r_wr_ptr - AW'({tau_eff, 1'b0})];
            r_b_pix          <= i_pixel;
            r_b_main         <= has_main;
            r_b_filt_ok      <= filt_ok;
            r_b_flush        <= n_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_col     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
                r_col    <= last ? '0 : r_col + 1'b1;
            end
            if (!b_stall) begin
                r_b_valid <= in_accept;
            end
        end
    end

    always_comb begin
        hi   = (r_b_left > r_b_pix) ? r_b_left : r_b_pix;
        diff = r_b_centre - hi;
        if (!r_b_filt_ok || (r_b_centre < r_gate) || (r_b_centre <= hi)) begin
            fval = '0;
        end else if (diff[PW-1]) begin
            fval = lmrf_pkg::PIX_MAX;
        end else begin
            fval = {diff[PW-2:0], 1'b0};
        end
    end

    assign o_cmd_push = r_b_valid && b_need && !i_cmd_full;
    assign o_cmd.main = r_b_main;
    assign o_cmd.fval = fval;
    assign o_cmd.rem  = r_b_flush;

    `LMRF_ASSERT_NEXT(a_row_restart, in_accept && last, r_col == '0, "column count did not restart")
    `LMRF_ASSERT(a_flush_only_last, r_b_valid && (r_b_flush != '0), !r_b_main || r_b_filt_ok || (r_b_flush <= tau_eff), "flush longer than tau")

endmodule

// ===== src/lmrf_back.sv =====
`include "lane_marking_row_filter_core_defines.svh"

module lmrf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lmrf_pkg::t_cmd             i_cmd,
    input  logic                       i_cmd_empty,
    output logic                       o_cmd_pop,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [lmrf_pkg::PIX_W-1:0] o_filtered,
    output logic                       o_row_end
);

    localparam int TW = lmrf_pkg::TAU_W;

    logic                       r_cur_valid;
    lmrf_pkg::t_cmd             r_cur;
    logic                       r_out_valid;
    logic [lmrf_pkg::PIX_W-1:0] r_out_filtered;
    logic                       r_out_row_end;

    logic adv;
    logic emit;
    logic cur_done;

    assign adv       = !r_out_valid || i_pop;
    assign emit      = adv && r_cur_valid;
    assign cur_done  = r_cur.main ? (r_cur.rem == '0) : (r_cur.rem == TW'(1));
    assign o_cmd_pop = !i_cmd_empty && (!r_cur_valid || (emit && cur_done));

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cur <= i_cmd;
        end else if (emit) begin
            if (r_cur.main) begin
                r_cur.main <= 1'b0;
            end else begin
                r_cur.rem <= r_cur.rem - 1'b1;
            end
        end
        if (emit) begin
            r_out_filtered <= r_cur.main ? r_cur.fval : '0;
            r_out_row_end  <= !r_cur.main && (r_cur.rem == TW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_cur_valid <= 1'b1;
            end else if (emit && cur_done) begin
                r_cur_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= r_cur_valid;
            end
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_filtered = r_out_filtered;
    assign o_row_end  = r_out_row_end;

    `LMRF_ASSERT(a_row_end_zero, r_out_valid && r_out_row_end, r_out_filtered == '0, "row end word not zero")
    `LMRF_ASSERT(a_cur_nonempty, r_cur_valid, r_cur.main || (r_cur.rem != '0), "empty command held")

endmodule

// ===== src/lane_marking_row_filter_core.sv =====
// Channel   Handshake            Payload
// input     i_push / o_full      i_pixel
// result    o_empty / i_pop      o_filtered, o_row_end
// config    i_cfg_we             i_cfg_index, i_cfg_data
//
// One pixel is taken per clock while o_full is low; the word for column c - tau goes from the
// front register stage through the command queue and command register to the output register.
// A row's last pixel also yields up to tau flush words, one per clock from the expander if popped.
// With the result side popping every cycle the expander keeps pace and the input never stalls;
// it stalls only once a held-off result side has filled the output stage and command queue.
// Reset is synchronous, clears counters and pointers, presets configuration; no clearing pass.
module lane_marking_row_filter_core #(
    parameter int TAU_MAX   = 16,
    parameter int MAX_WIDTH = 2048
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lmrf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lmrf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_push,
    input  logic [lmrf_pkg::PIX_W-1:0]       i_pixel,
    output logic                             o_full,
    output logic                             o_empty,
    input  logic                             i_pop,
    output logic [lmrf_pkg::PIX_W-1:0]       o_filtered,
    output logic                             o_row_end
);

    lmrf_pkg::t_cmd front_cmd;
    lmrf_pkg::t_cmd queue_cmd;
    logic           cmd_push;
    logic           cmd_full;
    logic           cmd_pop;
    logic           cmd_empty;

    lmrf_front #(
        .TAU_MAX   (TAU_MAX),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (i_push),
        .i_pixel     (i_pixel),
        .o_full      (o_full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (front_cmd),
        .i_cmd_full  (cmd_full)
    );

    lmrf_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (queue_cmd),
        .o_empty (cmd_empty)
    );

    lmrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_filtered  (o_filtered),
        .o_row_end   (o_row_end)
    );

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W       = lmrf_pkg::PIX_W;
    localparam int TAU_W       = lmrf_pkg::TAU_W;
    localparam int ROW_W       = lmrf_pkg::ROW_W;
    localparam int CFG_INDEX_W = lmrf_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = lmrf_pkg::CFG_DATA_W;

    localparam int TAU_LIMIT     = 16;
    localparam int WIDTH_LIMIT   = 2048;
    localparam int LINE_LEN      = 2 * TAU_LIMIT + 1;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_GUARD   = 20000;
    localparam int MAX_REPORTS   = 100;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] filtered;
        logic             row_end;
    } t_filt_word;

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_push      = 1'b0;
    logic [PIX_W-1:0]       i_pixel     = '0;
    logic                   o_full;
    logic                   o_empty;
    logic                   i_pop       = 1'b0;
    logic [PIX_W-1:0]       o_filtered;
    logic                   o_row_end;

    lane_marking_row_filter_core #(
        .TAU_MAX   (TAU_LIMIT),
        .MAX_WIDTH (WIDTH_LIMIT)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (i_push),
        .i_pixel     (i_pixel),
        .o_full      (o_full),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_filtered  (o_filtered),
        .o_row_end   (o_row_end)
    );

    logic [TAU_W-1:0] m_tau;
    logic [ROW_W-1:0] m_width;
    logic [PIX_W-1:0] m_gate;
    logic [PIX_W-1:0] m_line [LINE_LEN];
    int unsigned      m_col;

    t_filt_word queued_words[$];

    int err_count        = 0;
    int pixels_sent      = 0;
    int words_checked    = 0;
    int settings_used    = 0;
    int hold_request     = 0;
    bit push_idle_enable = 1'b1;
    bit pop_idle_enable  = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [PIX_W-1:0] line_filter(input logic [PIX_W-1:0] v,
                                                     input logic [PIX_W-1:0] a,
                                                     input logic [PIX_W-1:0] b);
        int hi;
        int d;
        hi = (a > b) ? a : b;
        if (v < m_gate) begin
            return '0;
        end
        d = 2 * int'(v) - 2 * hi;
        if (d < 0) begin
            return '0;
        end
        if (d > int'(lmrf_pkg::PIX_MAX)) begin
            return lmrf_pkg::PIX_MAX;
        end
        return d[PIX_W-1:0];
    endfunction

    function automatic void predict_row_filter(input logic [PIX_W-1:0] pix);
        int unsigned t;
        int unsigned w;
        int unsigned c;
        int unsigned j;
        int unsigned first_flush;
        int          k;
        bit          last;
        t_filt_word  word;
        t = (m_tau == 0) ? 1 : (m_tau > TAU_LIMIT) ? TAU_LIMIT : m_tau;
        w = (m_width == 0) ? 1 : (m_width > WIDTH_LIMIT) ? WIDTH_LIMIT : m_width;
        c = m_col;
        last = (c + 1 >= w);
        for (k = LINE_LEN - 1; k > 0; k--) begin
            m_line[k] = m_line[k-1];
        end
        m_line[0] = pix;
        if (c >= t) begin
            word.filtered = '0;
            word.row_end  = 1'b0;
            if (c >= 2 * t) begin
                word.filtered = line_filter(m_line[t], m_line[2*t], m_line[0]);
            end
            queued_words.push_back(word);
        end
        if (last) begin
            first_flush = (c >= t) ? c - t + 1 : 0;
            for (j = first_flush; j <= c; j++) begin
                word.filtered = '0;
                word.row_end  = (j == c);
                queued_words.push_back(word);
            end
            m_col = 0;
        end else begin
            m_col = c + 1;
        end
    endfunction

    function automatic logic [PIX_W-1:0] lane_pixel();
        case ($urandom_range(0, 2))
            0: begin
                return PIX_W'($urandom_range(0, 80));
            end
            1: begin
                return PIX_W'($urandom_range(170, 255));
            end
            default: begin
                return PIX_W'($urandom_range(0, 255));
            end
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        if (push_idle_enable && $urandom_range(0, 5) == 0) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_push  <= 1'b1;
        i_pixel <= pix;
        do @(posedge i_clk); while (o_full);
        predict_row_filter(pix);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            lmrf_pkg::CFG_TAU: begin
                m_tau = data[TAU_W-1:0];
            end
            lmrf_pkg::CFG_ROW_WIDTH: begin
                m_width = data[ROW_W-1:0];
            end
            lmrf_pkg::CFG_GATE_LEVEL: begin
                m_gate = data[PIX_W-1:0];
            end
            default: begin
            end
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Bits above the tau and gate registers' widths are filled with noise; the block must ignore them.
    task automatic set_config(input int unsigned tau, input int unsigned width,
                              input int unsigned gate);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom);
        write_reg(lmrf_pkg::CFG_TAU, (noise & 12'hFE0) | CFG_DATA_W'(tau));
        write_reg(lmrf_pkg::CFG_ROW_WIDTH, CFG_DATA_W'(width));
        write_reg(lmrf_pkg::CFG_GATE_LEVEL, (noise & 12'hF00) | CFG_DATA_W'(gate));
        settings_used++;
    endtask

    task automatic wait_for_results();
        int guard;
        guard = 0;
        i_push <= 1'b0;
        while (queued_words.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        if (queued_words.size() != 0) begin
            $display("%0t: %0d expected words missing, oldest filtered=%0d row_end=%0d",
                     $time, queued_words.size(), queued_words[0].filtered,
                     queued_words[0].row_end);
            err_count += queued_words.size();
            queued_words.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : result_side
        int         stall_left;
        int         hold_left;
        t_filt_word want;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_pop && !o_empty) begin
                words_checked++;
                if (queued_words.size() == 0) begin
                    err_count++;
                    if (err_count < MAX_REPORTS) begin
                        $display("%0t: extra word, expected none, got %0d/%0d",
                                 $time, o_filtered, o_row_end);
                    end
                end else begin
                    want = queued_words.pop_front();
                    if (o_filtered !== want.filtered) begin
                        err_count++;
                        if (err_count < MAX_REPORTS) begin
                            $display("%0t: filtered mismatch, expected %0d, got %0d",
                                     $time, want.filtered, o_filtered);
                        end
                    end
                    if (o_row_end !== want.row_end) begin
                        err_count++;
                        if (err_count < MAX_REPORTS) begin
                            $display("%0t: row_end mismatch, expected %0d, got %0d",
                                     $time, want.row_end, o_row_end);
                        end
                    end
                end
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_pop <= 1'b0;
            end else if (pop_idle_enable && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    task automatic test_reset_values();
        logic [PIX_W-1:0] pix [9];
        int               k;
        pix = '{8'd10, 8'd20, 8'd30, 8'd40, 8'd200, 8'd50, 8'd60, 8'd70, 8'd80};
        for (k = 0; k < 9; k++) begin
            send_pixel(pix[k]);
        end
        wait_for_results();
        // Lowering the width below the current column ends the row on the next pixel.
        write_reg(lmrf_pkg::CFG_ROW_WIDTH, CFG_DATA_W'(6));
        send_pixel(8'd255);
        wait_for_results();
    endtask

    task automatic test_value_extremes();
        logic [PIX_W-1:0] pix [15];
        int               k;
        pix = '{8'd0,   8'd255, 8'd0,
                8'd255, 8'd200, 8'd0,
                8'd0,   8'd129, 8'd0,
                8'd0,   8'd130, 8'd0,
                8'd150, 8'd200, 8'd100};
        set_config(1, 3, 130);
        for (k = 0; k < 15; k++) begin
            send_pixel(pix[k]);
        end
        wait_for_results();
    endtask

    task automatic test_register_extremes();
        set_config(0, 0, 0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        wait_for_results();
        write_reg(CFG_UNUSED, 12'hFFF);
        send_pixel(8'hAA);
        wait_for_results();
    endtask

    task automatic test_random_settings();
        int          ph;
        int          k;
        int unsigned r;
        int unsigned tau;
        int unsigned width;
        int unsigned gate;
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    tau = TAU_LIMIT;
                    width = WIDTH_LIMIT;
                    gate = 0;
                end
                1: begin
                    tau = 31;
                    width = 4095;
                    gate = 255;
                end
                default: begin
                    r = $urandom_range(0, 9);
                    tau = (r == 0) ? $urandom_range(17, 31) :
                          (r == 1) ? 0 : $urandom_range(1, TAU_LIMIT);
                    r = $urandom_range(0, 9);
                    if (r < 4) begin
                        width = $urandom_range(33, 64);
                    end else if (r < 7) begin
                        width = $urandom_range(2, 32);
                    end else if (r == 7) begin
                        width = $urandom_range(0, 1);
                    end else begin
                        width = $urandom_range(65, 300);
                    end
                    gate = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(60, 220);
                end
            endcase
            set_config(tau, width, gate);
            for (k = 0; k < 20; k++) begin
                send_pixel(lane_pixel());
            end
            wait_for_results();
        end
    endtask

    task automatic test_backpressure();
        set_config(TAU_LIMIT, 33, 100);
        push_idle_enable = 1'b0;
        hold_request = 400;
        repeat (60) send_pixel(lane_pixel());
        push_idle_enable = 1'b1;
        wait_for_results();
    endtask

    task automatic test_steady_stream();
        push_idle_enable = 1'b0;
        pop_idle_enable  = 1'b0;
        set_config($urandom_range(1, TAU_LIMIT), $urandom_range(33, 48),
                   $urandom_range(100, 160));
        repeat (30) send_pixel(lane_pixel());
        wait_for_results();
    endtask

    initial begin
        int k;
        m_tau   = lmrf_pkg::TAU_RESET;
        m_width = lmrf_pkg::ROW_WIDTH_RESET;
        m_gate  = lmrf_pkg::GATE_RESET;
        m_col   = 0;
        for (k = 0; k < LINE_LEN; k++) begin
            m_line[k] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_value_extremes();
        test_register_extremes();
        test_random_settings();
        test_backpressure();
        test_steady_stream();
        $display("Covered %0d pixels, %0d result words and %0d register settings.",
                 pixels_sent, words_checked, settings_used);
        $display("Included saturation, gating, row flushes, odd registers and a hold-off.");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/lmrf_pkg.sv
src/lmrf_cmd_queue.sv
src/lmrf_front.sv
src/lmrf_back.sv
src/lane_marking_row_filter_core.sv
tb/tb.sv
